// ===== sv/gqg_pkg.sv =====
// ----------------------------------------------------------------------------
// gqg_pkg
// Types, codes and the atlas cell lookup shared by the glyph quad generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gqg_pkg;

    localparam logic [6:0]  CODE_NEWLINE = 7'd10;
    localparam logic [15:0] ADV_Q16      = 16'd42598;
    localparam logic [15:0] CELL_U       = 16'd736;
    localparam logic [15:0] CELL_V       = 16'd2048;
    localparam int          PEN_W        = 21;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_FONT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_FONT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SCALE_X     = 3'd4;
    localparam logic [2:0] REG_SCALE_Y     = 3'd5;

    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [11:0] font_width;
        logic [11:0] font_height;
        logic [23:0] scale_x;
        logic [23:0] scale_y;
    } t_cfg;

    typedef struct packed {
        logic [PEN_W-1:0] pen_x;
        logic [PEN_W-1:0] pen_y;
        logic [11:0]      font_width;
        logic [11:0]      font_height;
        logic [15:0]      tex_u0;
        logic [15:0]      tex_v0;
        logic [15:0]      vertex_base;
    } t_job;

    typedef struct packed {
        logic [15:0] u0;
        logic [15:0] v0;
    } t_tex;

    // atlas cell origin, 22 glyphs per row, truncating row division
    function automatic t_tex cell_origin(input logic [6:0] code);
        logic signed [7:0]  d;
        logic signed [3:0]  line;
        logic signed [7:0]  col;
        logic signed [15:0] col16;
        logic signed [15:0] line16;
        t_tex               res;
        d = $signed({1'b0, code}) - 8'sd32;
        if (d <= -8'sd22)      line = -4'sd1;
        else if (d < 8'sd22)   line = 4'sd0;
        else if (d < 8'sd44)   line = 4'sd1;
        else if (d < 8'sd66)   line = 4'sd2;
        else if (d < 8'sd88)   line = 4'sd3;
        else                   line = 4'sd4;
        col    = d - ($signed({{4{line[3]}}, line}) * 8'sd22);
        col16  = {{8{col[7]}}, col};
        line16 = {{12{line[3]}}, line};
        res.u0 = col16 * $signed(CELL_U);
        res.v0 = line16 <<< 11;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gqg_front.sv =====
// ----------------------------------------------------------------------------
// gqg_front
// Accepts character items, keeps the pen and vertex count, pushes glyph jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module gqg_front
    import gqg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [6:0] i_char_code,
    input  wire logic       i_restart,
    input  wire logic       i_queue_full,
    output logic            o_push,
    output t_job            o_job
);

    logic [PEN_W-1:0] r_pen_x, n_pen_x;
    logic [PEN_W-1:0] r_pen_y, n_pen_y;
    logic [15:0]      r_vt, n_vt;
    logic [PEN_W-1:0] base_x, base_y;
    logic [15:0]      base_vt;
    logic [28:0]      adv_full;
    logic [11:0]      adv;
    logic             accept;
    logic             is_newline;
    t_tex             tex;

    assign o_ready    = !i_queue_full;
    assign accept     = i_valid && !i_queue_full;
    assign is_newline = (i_char_code == CODE_NEWLINE);
    assign adv_full   = {17'd0, i_cfg.font_width} * {13'd0, ADV_Q16} + 29'd32768;
    assign adv        = adv_full[27:16];
    assign tex        = cell_origin(i_char_code);

    always_comb begin
        base_x  = i_restart ? {5'd0, i_cfg.origin_x} : r_pen_x;
        base_y  = i_restart ? {5'd0, i_cfg.origin_y} : r_pen_y;
        base_vt = i_restart ? 16'd0 : r_vt;
        n_pen_x = r_pen_x;
        n_pen_y = r_pen_y;
        n_vt    = r_vt;
        o_push  = 1'b0;
        if (accept) begin
            if (is_newline) begin
                n_pen_x = {5'd0, i_cfg.origin_x};
                n_pen_y = base_y - {9'd0, i_cfg.font_height};
                n_vt    = base_vt;
            end else begin
                o_push  = 1'b1;
                n_pen_x = base_x + {9'd0, adv};
                n_pen_y = base_y;
                n_vt    = base_vt + 16'd4;
            end
        end
    end

    always_comb begin
        o_job.pen_x       = base_x;
        o_job.pen_y       = base_y;
        o_job.font_width  = i_cfg.font_width;
        o_job.font_height = i_cfg.font_height;
        o_job.tex_u0      = tex.u0;
        o_job.tex_v0      = tex.v0;
        o_job.vertex_base = base_vt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_vt    <= '0;
        end else begin
            r_pen_x <= n_pen_x;
            r_pen_y <= n_pen_y;
            r_vt    <= n_vt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gqg_queue.sv =====
// ----------------------------------------------------------------------------
// gqg_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gqg_queue
    import gqg_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gqg_back.sv =====
// ----------------------------------------------------------------------------
// gqg_back
// Scales quad corners to normalized coordinates and sends four vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module gqg_back
    import gqg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_job_valid,
    input  wire t_job  i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [79:0] o_data,
    output logic       o_last
);

    function automatic logic [15:0] ndc_round(input logic signed [46:0] prod);
        logic signed [47:0] biased;
        logic signed [31:0] q12;
        logic signed [31:0] d;
        logic [15:0]        res;
        biased = {prod[46], prod} + 48'sd32768;
        q12    = biased[47:16];
        d      = q12 - 32'sd4096;
        if (d > 32'sd32767)       res = 16'h7FFF;
        else if (d < -32'sd32768) res = 16'h8000;
        else                      res = d[15:0];
        return res;
    endfunction

    logic signed [21:0] px0, px1, py0, py1;
    logic signed [24:0] sx, sy;

    logic               r_a_valid;
    logic signed [46:0] r_a_x0, r_a_x1, r_a_y0, r_a_y1;
    logic [15:0]        r_a_u0, r_a_v0, r_a_vt;

    logic               r_q_valid;
    logic [1:0]         r_idx;
    logic [15:0]        r_x0, r_x1, r_y0, r_y1, r_u0, r_v0, r_vt;

    logic               a_load, b_load, q_done, out_fire;
    logic [15:0]        vx, vy, vu, vv, vn;

    assign px0 = {i_job.pen_x[PEN_W-1], i_job.pen_x};
    assign py0 = {i_job.pen_y[PEN_W-1], i_job.pen_y};
    assign px1 = px0 + $signed({10'd0, i_job.font_width});
    assign py1 = py0 + $signed({10'd0, i_job.font_height});
    assign sx  = $signed({1'b0, i_cfg.scale_x});
    assign sy  = $signed({1'b0, i_cfg.scale_y});

    assign out_fire = r_q_valid && i_ready;
    assign q_done   = out_fire && (r_idx == 2'd3);
    assign b_load   = r_a_valid && (!r_q_valid || q_done);
    assign a_load   = !r_a_valid || b_load;
    assign o_pop    = i_job_valid && a_load;

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_x0 <= px0 * sx;
            r_a_x1 <= px1 * sx;
            r_a_y0 <= py0 * sy;
            r_a_y1 <= py1 * sy;
            r_a_u0 <= i_job.tex_u0;
            r_a_v0 <= i_job.tex_v0;
            r_a_vt <= i_job.vertex_base;
        end
        if (b_load) begin
            r_x0 <= ndc_round(r_a_x0);
            r_x1 <= ndc_round(r_a_x1);
            r_y0 <= ndc_round(r_a_y0);
            r_y1 <= ndc_round(r_a_y1);
            r_u0 <= r_a_u0;
            r_v0 <= r_a_v0;
            r_vt <= r_a_vt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_idx     <= 2'd0;
        end else begin
            if (a_load) begin
                r_a_valid <= i_job_valid;
            end
            if (b_load) begin
                r_q_valid <= 1'b1;
            end else if (q_done) begin
                r_q_valid <= 1'b0;
            end
            if (out_fire) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_comb begin
        vx = ((r_idx == 2'd0) || (r_idx == 2'd3)) ? r_x0 : r_x1;
        vy = (r_idx[1] == 1'b0) ? r_y0 : r_y1;
        vu = ((r_idx == 2'd0) || (r_idx == 2'd3)) ? r_u0 : r_u0 + CELL_U;
        vv = (r_idx[1] == 1'b0) ? r_v0 + CELL_V : r_v0;
        vn = r_vt + {14'd0, r_idx};
    end

    assign o_valid = r_q_valid;
    assign o_data  = {vn, vv, vu, vy, vx};
    assign o_last  = (r_idx == 2'd3);

endmodule

`default_nettype wire

// ===== sv/glyph_quad_generator_top.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_generator_top
// Text quad generator: character codes in, atlas-mapped quad vertices out.
//
// channel   | direction | content
// s_axis    | in        | tdata[6:0] char_code, tuser restart
// m_axis    | out       | tdata pos_x, pos_y, tex_u, tex_v, vertex_number; tlast
// apb       | in/out    | six configuration registers at 4*i
//
// A glyph gives four vertices on the result channel, one vertex per cycle while
// the result channel is ready; a newline yields nothing. The first vertex passes
// through the queue, the multiply stage and the round stage.
// The job queue lets the input side run on while results stall.
// Reset clears the pen, vertex count and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_quad_generator_top
    import gqg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // char_code[6:0], pad
    input  wire logic        i_s_axis_tuser,   // restart
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // pos_x, pos_y, tex_u, tex_v, vertex_number
    output logic             o_m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;
    logic       q_full, q_push, q_pop, q_valid;
    t_job       push_job, head_job;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= 16'd0;
            r_cfg.origin_y    <= 16'd0;
            r_cfg.font_width  <= 12'd320;
            r_cfg.font_height <= 12'd368;
            r_cfg.scale_x     <= 24'd41943;
            r_cfg.scale_y     <= 24'd55924;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ORIGIN_X:    r_cfg.origin_x    <= pwdata[15:0];
                REG_ORIGIN_Y:    r_cfg.origin_y    <= pwdata[15:0];
                REG_FONT_WIDTH:  r_cfg.font_width  <= pwdata[11:0];
                REG_FONT_HEIGHT: r_cfg.font_height <= pwdata[11:0];
                REG_SCALE_X:     r_cfg.scale_x     <= pwdata[23:0];
                REG_SCALE_Y:     r_cfg.scale_y     <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ORIGIN_X:    prdata = {16'd0, r_cfg.origin_x};
            REG_ORIGIN_Y:    prdata = {16'd0, r_cfg.origin_y};
            REG_FONT_WIDTH:  prdata = {20'd0, r_cfg.font_width};
            REG_FONT_HEIGHT: prdata = {20'd0, r_cfg.font_height};
            REG_SCALE_X:     prdata = {8'd0, r_cfg.scale_x};
            REG_SCALE_Y:     prdata = {8'd0, r_cfg.scale_y};
            default:         prdata = 32'd0;
        endcase
    end

    gqg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_char_code  (i_s_axis_tdata[6:0]),
        .i_restart    (i_s_axis_tuser),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_job        (push_job)
    );

    gqg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    gqg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
